>>> rtl/rct_pkg.sv
// Shared types and codes for the reference count table.
// Used by rct_ctrl, rct_datapath and reference_count_table.
package rct_pkg;

    localparam int OPCODE_W = 3;
    localparam int ID_W     = 8;
    localparam int LEN_W    = 9;
    localparam int STATUS_W = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_LIFT    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_DROP    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SWEEP   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RESERVE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REDUCED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HANGING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOST    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_ID  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_SAT     = 3'd7;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic read;
        logic eval;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic finish;
    } t_stat;

endpackage

>>> rtl/reference_count_table.sv
// Reference count table top level: stream ports around rct_ctrl and rct_datapath.
// Lift, drop, unknown opcodes and trivial reserves finish after a single entry read and
// evaluation; scans read and evaluate one entry at a time through the single-port entry
// memory (allocate and sweep examine up to TABLE_DEPTH entries, reserve up to 2*TABLE_DEPTH).
// Throughput: one request at a time; the next is taken once the previous result is stored.
// Reset: synchronous active low; a clearing pass then writes every entry to zero, no requests.
module reference_count_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // entry_id [7:0], run_length [16:8], zero fill above
    input  logic [rct_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // opcode [2:0]
    input  logic [rct_pkg::OPCODE_W-1:0]        i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // result_id [7:0], more_pending [8], zero fill above
    output logic [rct_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // status [2:0]
    output logic [rct_pkg::STATUS_W-1:0]        o_m_axis_tuser
);
    import rct_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [ID_W-1:0]   result_id;
    logic              more_pending;

    rct_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    rct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (i_s_axis_tuser),
        .i_entry_id     (i_s_axis_tdata[ID_W-1:0]),
        .i_run_length   (i_s_axis_tdata[ID_W+LEN_W-1:ID_W]),
        .o_status       (o_m_axis_tuser),
        .o_result_id    (result_id),
        .o_more_pending (more_pending)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - ID_W - 1)'(0), more_pending, result_id};

endmodule

>>> rtl/rct_ctrl.sv
// Controller state machine for the reference count table.
// Depends on rct_pkg; drives rct_datapath through t_cmd.
module rct_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    input  rct_pkg::t_stat i_stat,
    output rct_pkg::t_cmd  o_cmd
);
    import rct_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld;
    logic   out_free;

    assign out_free = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_stat.clear_last) n_state = S_IDLE;
            S_IDLE:  if (i_s_axis_tvalid) n_state = S_READ;
            S_READ:  n_state = S_EVAL;
            S_EVAL:  n_state = i_stat.finish ? S_DONE : S_READ;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clear = 1'b1;
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.load      = i_s_axis_tvalid;
            end
            S_READ:  o_cmd.read = 1'b1;
            S_EVAL:  o_cmd.eval = 1'b1;
            S_DONE:  o_cmd.emit = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;

`ifndef ASSERT_OFF
    // a result appears only out of the done state
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");

    // every evaluation follows a read of the entry
    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL |-> $past(r_state) == S_READ)
        else $error("evaluation without a preceding read");

    // an accepted request starts a read in the next cycle
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_state == S_READ)
        else $error("accepted request did not start");
`endif

endmodule

>>> rtl/rct_datapath.sv
// Datapath of the reference count table: entry memory, scan pointer,
// hint and result registers. Depends on rct_pkg; sequenced by rct_ctrl.
module rct_datapath #(
    parameter int TABLE_DEPTH = 256,
    parameter int COUNT_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rct_pkg::t_cmd                  i_cmd,
    output rct_pkg::t_stat                 o_stat,
    input  logic [rct_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [rct_pkg::ID_W-1:0]       i_entry_id,
    input  logic [rct_pkg::LEN_W-1:0]      i_run_length,
    output logic [rct_pkg::STATUS_W-1:0]   o_status,
    output logic [rct_pkg::ID_W-1:0]       o_result_id,
    output logic                           o_more_pending
);
    import rct_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = (AW > ID_W) ? AW : ID_W;
    localparam int EW = COUNT_BITS + 1;
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    // entry layout: valid bit on top, count below
    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] r_rd;

    logic [OPCODE_W-1:0] r_op;
    logic [ID_W-1:0]     r_id;
    logic [LEN_W-1:0]    r_len;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [AW-1:0]       r_steps, n_steps;
    logic                r_phase, n_phase;
    logic [AW-1:0]       r_found, n_found;
    logic [LEN_W-1:0]    r_run, n_run;
    logic [AW-1:0]       r_hint, n_hint;
    logic [STATUS_W-1:0] r_res_st, n_res_st;
    logic [ID_W-1:0]     r_res_id, n_res_id;
    logic                r_res_more, n_res_more;
    logic [STATUS_W-1:0] r_o_st;
    logic [ID_W-1:0]     r_o_id;
    logic                r_o_more;

    logic                   fin;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [EW-1:0]          mem_wd;
    logic [AW-1:0]          ptr_nx;
    logic [AW-1:0]          start_ptr;
    logic [AW-1:0]          run_start;
    logic [IW-1:0]          id_w, ptr_w, found_w, start_w, hint_w;
    logic [COUNT_BITS-1:0]  cnt;
    logic                   vld;
    logic                   hit0;
    logic                   id_bad;
    logic                   len_big;

    assign cnt     = r_rd[COUNT_BITS-1:0];
    assign vld     = r_rd[COUNT_BITS];
    assign hit0    = vld && (cnt == '0);
    assign ptr_nx  = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;
    assign id_w    = IW'(i_entry_id);
    assign ptr_w   = IW'(r_ptr);
    assign found_w = IW'(r_found);
    assign hint_w  = IW'(r_hint);
    assign id_bad  = 32'(r_id) >= TABLE_DEPTH;
    assign len_big = 32'(r_len) > TABLE_DEPTH;
    assign run_start = AW'(32'(r_ptr) + 32'd1 - 32'(r_len));
    assign start_w = IW'(run_start);

    always_comb begin
        case (i_opcode)
            OP_LIFT, OP_DROP: start_ptr = id_w[AW-1:0];
            OP_SWEEP:         start_ptr = '0;
            default:          start_ptr = r_hint;
        endcase
    end

    // one step of the current request on the entry just read
    always_comb begin
        fin        = 1'b0;
        n_ptr      = r_ptr;
        n_steps    = r_steps;
        n_phase    = r_phase;
        n_found    = r_found;
        n_run      = r_run;
        n_hint     = r_hint;
        wr_en      = 1'b0;
        wr_addr    = r_ptr;
        wr_data    = '0;
        n_res_st   = ST_DONE;
        n_res_id   = '0;
        n_res_more = 1'b0;
        case (r_op)
            OP_ALLOC: begin
                if (!vld) begin
                    fin      = 1'b1;
                    wr_en    = 1'b1;
                    wr_data  = {1'b1, COUNT_BITS'(1)};
                    n_hint   = ptr_nx;
                    n_res_id = ptr_w[ID_W-1:0];
                end else if (r_steps == LAST) begin
                    fin      = 1'b1;
                    n_res_st = ST_FULL;
                end else begin
                    n_ptr   = ptr_nx;
                    n_steps = r_steps + 1'b1;
                end
            end
            OP_LIFT: begin
                fin = 1'b1;
                if (id_bad || !vld) begin
                    n_res_st = ST_BAD_ID;
                end else if (cnt == '1) begin
                    n_res_st = ST_SAT;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, cnt + 1'b1};
                end
            end
            OP_DROP: begin
                fin = 1'b1;
                if (id_bad || !vld || cnt == '0) begin
                    n_res_st = ST_BAD_ID;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, cnt - 1'b1};
                    if (cnt == COUNT_BITS'(2)) begin
                        n_res_st = ST_HANGING;
                    end else if (cnt == COUNT_BITS'(1)) begin
                        n_res_st = ST_LOST;
                    end else begin
                        n_res_st = ST_REDUCED;
                    end
                end
            end
            OP_SWEEP: begin
                if (!r_phase) begin
                    if (hit0) begin
                        n_found = r_ptr;
                        n_phase = 1'b1;
                        if (r_ptr == LAST) begin
                            fin      = 1'b1;
                            wr_en    = 1'b1;
                            wr_data  = {1'b0, cnt};
                            n_res_id = ptr_w[ID_W-1:0];
                        end else begin
                            n_ptr = ptr_nx;
                        end
                    end else if (r_ptr == LAST) begin
                        fin      = 1'b1;
                        n_res_st = ST_EMPTY;
                    end else begin
                        n_ptr = ptr_nx;
                    end
                end else if (hit0 || r_ptr == LAST) begin
                    // free the first hit, flag whether a second one exists
                    fin        = 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = r_found;
                    n_res_id   = found_w[ID_W-1:0];
                    n_res_more = hit0;
                end else begin
                    n_ptr = ptr_nx;
                end
            end
            OP_RESERVE: begin
                if (r_len == '0) begin
                    fin      = 1'b1;
                    n_res_id = hint_w[ID_W-1:0];
                end else if (len_big) begin
                    fin      = 1'b1;
                    n_res_st = ST_FULL;
                end else if (!vld && (r_run + LEN_W'(1)) == r_len) begin
                    fin      = 1'b1;
                    n_hint   = run_start;
                    n_res_id = start_w[ID_W-1:0];
                end else begin
                    n_run = vld ? '0 : r_run + LEN_W'(1);
                    if (r_ptr == LAST) begin
                        // first pass ends at the top; second pass from id zero
                        if (!r_phase) begin
                            n_phase = 1'b1;
                            n_ptr   = '0;
                            n_run   = '0;
                        end else begin
                            fin      = 1'b1;
                            n_res_st = ST_FULL;
                        end
                    end else begin
                        n_ptr = ptr_nx;
                    end
                end
            end
            default: begin
                fin      = 1'b1;
                n_res_st = ST_BAD_ID;
            end
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ptr;
        mem_wd = '0;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
        end else if (i_cmd.eval && wr_en) begin
            mem_we = 1'b1;
            mem_wa = wr_addr;
            mem_wd = wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.read) begin
            r_rd <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_hint <= '0;
        end else if (i_cmd.clear) begin
            r_ptr <= ptr_nx;
        end else if (i_cmd.load) begin
            r_ptr <= start_ptr;
        end else if (i_cmd.eval) begin
            r_ptr  <= n_ptr;
            r_hint <= n_hint;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_id    <= i_entry_id;
            r_len   <= i_run_length;
            r_steps <= '0;
            r_phase <= 1'b0;
            r_run   <= '0;
            r_found <= '0;
        end else if (i_cmd.eval) begin
            r_steps <= n_steps;
            r_phase <= n_phase;
            r_run   <= n_run;
            r_found <= n_found;
        end
        if (i_cmd.eval && fin) begin
            r_res_st   <= n_res_st;
            r_res_id   <= n_res_id;
            r_res_more <= n_res_more;
        end
        if (i_cmd.emit) begin
            r_o_st   <= r_res_st;
            r_o_id   <= r_res_id;
            r_o_more <= r_res_more;
        end
    end

    assign o_stat.clear_last = (r_ptr == LAST);
    assign o_stat.finish     = fin;
    assign o_status          = r_o_st;
    assign o_result_id       = r_o_id;
    assign o_more_pending    = r_o_more;

`ifndef ASSERT_OFF
    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hint) < TABLE_DEPTH)
        else $error("hint beyond table");

    // the hint moves only when a request finishes
    a_hint_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_hint != $past(r_hint)) |-> $past(i_cmd.eval && fin))
        else $error("hint moved outside a finishing step");

    // the memory is written only by the clearing pass or an evaluation
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (i_cmd.clear || i_cmd.eval))
        else $error("stray memory write");
`endif

endmodule

>>> verif/reference_count_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for reference_count_table: handle table opcodes on the request stream.
// Depends on rct_pkg and the reference_count_table RTL; keeps its own model of the table.
module reference_count_table_tb;
    import rct_pkg::*;

    localparam int DEPTH          = 256;
    localparam int COUNT_W        = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam int RANDOM_ITEMS   = 684;
    localparam int BURST_LIFTS    = 24;
    localparam int TAIL_CYCLES    = 4 * DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 4 * (5 * DEPTH + 64);
    localparam int REPORT_CAP     = 100;

    // Opcodes the block does not implement
    localparam logic [OPCODE_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     rid;
        logic                more;
    } t_reply;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [ID_W-1:0]     id;
        logic [LEN_W-1:0]    len;
        logic                typed;
        t_reply              reply;
    } t_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic [IN_DATA_W-1:0]  req_data = '0;
    logic [OPCODE_W-1:0]   req_user = '0;
    logic                  rsp_ready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [STATUS_W-1:0]   o_m_axis_tuser;

    // Table model
    bit                 live [DEPTH];
    logic [COUNT_W-1:0] refs [DEPTH];
    int                 free_hint;

    t_reply pending_replies [$];
    t_row   plan [$];
    int     errors;
    int     requests_sent;
    int     replies_checked;
    int     status_seen [8];
    int     quiet_cycles;
    bit     tx_calm;
    bit     rx_calm;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    reference_count_table #(
        .TABLE_DEPTH (DEPTH),
        .COUNT_BITS  (COUNT_W)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    function automatic int first_zero_ref(input int from);
        int k;
        for (k = from; k < DEPTH; k++)
            if (live[k] && refs[k] == '0) return k;
        return -1;
    endfunction

    function automatic int find_free_run(input int lo, input int hi, input int len);
        int k;
        int run;
        run = 0;
        for (k = lo; k < hi; k++) begin
            if (live[k]) begin
                run = 0;
            end else begin
                run++;
                if (run == len) return k + 1 - len;
            end
        end
        return -1;
    endfunction

    // Apply one request to the table model and return the reply it must produce
    function automatic t_reply apply_request(input logic [OPCODE_W-1:0] op,
                                             input logic [ID_W-1:0] id,
                                             input logic [LEN_W-1:0] len);
        t_reply r;
        int     k;
        int     pos;
        int     start;
        bit     hit;
        r = '0;
        case (op)
            OP_ALLOC: begin
                r.status = ST_FULL;
                hit = 1'b0;
                for (k = 0; k < DEPTH && !hit; k++) begin
                    pos = (free_hint + k) % DEPTH;
                    if (!live[pos]) begin
                        hit = 1'b1;
                        live[pos] = 1'b1;
                        refs[pos] = COUNT_W'(1);
                        free_hint = (pos + 1) % DEPTH;
                        r.status = ST_DONE;
                        r.rid = ID_W'(pos);
                    end
                end
            end
            OP_LIFT: begin
                if (!live[id]) begin
                    r.status = ST_BAD_ID;
                end else if (refs[id] == COUNT_MAX) begin
                    r.status = ST_SAT;
                end else begin
                    refs[id] = refs[id] + 1'b1;
                    r.status = ST_DONE;
                end
            end
            OP_DROP: begin
                if (!live[id] || refs[id] == '0) begin
                    r.status = ST_BAD_ID;
                end else begin
                    refs[id] = refs[id] - 1'b1;
                    if (refs[id] == 1)
                        r.status = ST_HANGING;
                    else if (refs[id] == 0)
                        r.status = ST_LOST;
                    else
                        r.status = ST_REDUCED;
                end
            end
            OP_SWEEP: begin
                start = first_zero_ref(0);
                if (start < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    live[start] = 1'b0;
                    r.status = ST_DONE;
                    r.rid = ID_W'(start);
                    r.more = (first_zero_ref(start + 1) >= 0);
                end
            end
            OP_RESERVE: begin
                if (len == '0) begin
                    r.status = ST_DONE;
                    r.rid = ID_W'(free_hint);
                end else if (len > DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // try from the hint to the end first, then from the bottom
                    start = find_free_run(free_hint, DEPTH, int'(len));
                    if (start < 0) start = find_free_run(0, DEPTH, int'(len));
                    if (start < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        free_hint = start;
                        r.status = ST_DONE;
                        r.rid = ID_W'(start);
                    end
                end
            end
            default: r.status = ST_BAD_ID;
        endcase
        return r;
    endfunction

    function automatic logic [ID_W-1:0] pick_live(input bit need_refs);
        logic [ID_W-1:0] cand;
        int              tries;
        cand = '0;
        for (tries = 0; tries < 16; tries++) begin
            cand = ID_W'($urandom_range(0, DEPTH - 1));
            if (live[cand] && (!need_refs || refs[cand] != '0)) return cand;
        end
        return cand;
    endfunction

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // Present one request, hold it until taken, then record the reply it must get
    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [LEN_W-1:0] len, input bit typed,
                                input t_reply typed_reply);
        int     gap;
        t_reply predicted;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= {{(IN_DATA_W - ID_W - LEN_W){1'b0}}, len, id};
        req_user  <= op;
        do @(posedge clk); while (o_s_axis_tready !== 1'b1);
        predicted = apply_request(op, id, len);
        pending_replies.push_back(typed ? typed_reply : predicted);
        requests_sent++;
    endtask

    // Hold off new requests until every outstanding reply is back
    task automatic drain_replies();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_replies.size() != 0);
    endtask

    task automatic add_row(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [LEN_W-1:0] len, input bit typed,
                           input logic [STATUS_W-1:0] status, input logic [ID_W-1:0] rid,
                           input logic more);
        t_row row;
        row.op = op;
        row.id = id;
        row.len = len;
        row.typed = typed;
        row.reply.status = status;
        row.reply.rid = rid;
        row.reply.more = more;
        plan.push_back(row);
    endtask

    task automatic check_reply(input t_reply got);
        t_reply want;
        status_seen[got.status]++;
        replies_checked++;
        if (pending_replies.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: unexpected reply, expected none, got status %0d id %0d more %0d",
                         $time, got.status, got.rid, got.more);
        end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, got.status);
            end
            if (got.rid !== want.rid) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: result_id mismatch, expected %0d, got %0d",
                             $time, want.rid, got.rid);
            end
            if (got.more !== want.more) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: more_pending mismatch, expected %0d, got %0d",
                             $time, want.more, got.more);
            end
        end
    endtask

    // Reply side: stall at random unless rx_calm is set, then take one reply
    initial begin : reply_sink
        int     stall;
        t_reply got;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_wait(rx_calm);
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (o_m_axis_tvalid !== 1'b1);
            got.status = o_m_axis_tuser;
            got.rid    = o_m_axis_tdata[ID_W-1:0];
            got.more   = o_m_axis_tdata[ID_W];
            check_reply(got);
        end
    end

    always @(posedge clk) begin
        if ((req_valid && o_s_axis_tready === 1'b1) ||
            (rsp_ready && o_m_axis_tvalid === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int                  n;
        int                  pick;
        int                  hot_id;
        logic [OPCODE_W-1:0] op;
        logic [ID_W-1:0]     id;
        logic [LEN_W-1:0]    len;
        for (n = 0; n < DEPTH; n++) begin
            live[n] = 1'b0;
            refs[n] = '0;
        end
        free_hint = 0;
        errors = 0;
        requests_sent = 0;
        replies_checked = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // Directed: empty table, extremes, every opcode, drop ladder, sweep order
        add_row(OP_SWEEP,    8'd0,   9'd0,   1, ST_EMPTY,  8'd0, 1'b0);
        add_row(OP_LIFT,     8'd0,   9'd0,   1, ST_BAD_ID, 8'd0, 1'b0);
        add_row(OP_DROP,     8'd255, 9'd0,   1, ST_BAD_ID, 8'd0, 1'b0);
        add_row(OP_RESERVE,  8'd0,   9'd0,   1, ST_DONE,   8'd0, 1'b0);
        add_row(OP_RESERVE,  8'd0,   9'd257, 1, ST_FULL,   8'd0, 1'b0);
        add_row(OP_RESERVE,  8'd255, 9'd511, 1, ST_FULL,   8'd0, 1'b0);
        add_row(OP_RESERVE,  8'd0,   9'd256, 1, ST_DONE,   8'd0, 1'b0);
        add_row(OP_ALLOC,    8'd0,   9'd0,   1, ST_DONE,   8'd0, 1'b0);
        add_row(OP_ALLOC,    8'd0,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_RESERVE,  8'd0,   9'd256, 1, ST_FULL,   8'd0, 1'b0);
        add_row(OP_RESERVE,  8'd0,   9'd254, 0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_LIFT,     8'd0,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_DROP,     8'd0,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_LIFT,     8'd0,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_LIFT,     8'd0,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_DROP,     8'd0,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_DROP,     8'd0,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_DROP,     8'd0,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_DROP,     8'd0,   9'd0,   1, ST_BAD_ID, 8'd0, 1'b0);
        add_row(OP_DROP,     8'd1,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_SWEEP,    8'd0,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_SWEEP,    8'd0,   9'd0,   0, ST_DONE,   8'd0, 1'b0);
        add_row(OP_SWEEP,    8'd0,   9'd0,   1, ST_EMPTY,  8'd0, 1'b0);
        add_row(OP_UNUSED_5, 8'hFF,  9'h1FF, 1, ST_BAD_ID, 8'd0, 1'b0);
        add_row(OP_UNUSED_6, 8'hAA,  9'h155, 1, ST_BAD_ID, 8'd0, 1'b0);
        add_row(OP_UNUSED_7, 8'h55,  9'h0AA, 1, ST_BAD_ID, 8'd0, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_request(plan[i].op, plan[i].id, plan[i].len, plan[i].typed, plan[i].reply);
        drain_replies();

        // Fill the table; the hint wraps past the last id on the way
        for (n = 0; n < DEPTH; n++)
            send_request(OP_ALLOC, ID_W'($urandom), LEN_W'($urandom_range(0, 511)),
                         1'b0, '0);
        send_request(OP_ALLOC, 8'd0, 9'd0, 1'b1, '{ST_FULL, 8'd0, 1'b0});
        send_request(OP_RESERVE, 8'd0, 9'd1, 1'b1, '{ST_FULL, 8'd0, 1'b0});
        send_request(OP_SWEEP, 8'd0, 9'd0, 1'b1, '{ST_EMPTY, 8'd0, 1'b0});
        drain_replies();

        // Lift one count in a burst, back to back on both sides
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        hot_id = $urandom_range(0, DEPTH - 1);
        repeat (BURST_LIFTS)
            send_request(OP_LIFT, ID_W'(hot_id), 9'd0, 1'b0, '0);
        send_request(OP_DROP, ID_W'(hot_id), 9'd0, 1'b0, '0);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // Drop one reference from every entry so that sweeps have plenty to free
        for (n = 0; n < DEPTH; n++)
            send_request(OP_DROP, ID_W'(n), LEN_W'($urandom_range(0, 511)), 1'b0, '0);
        drain_replies();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (n % 97 == 50 && $urandom_range(0, 1) == 1)
                drain_replies();
            pick = $urandom_range(0, 99);
            op = OP_ALLOC;
            id = ID_W'($urandom);
            len = LEN_W'($urandom_range(1, 16));
            if (pick < 22) begin
                op = OP_ALLOC;
            end else if (pick < 40) begin
                op = OP_LIFT;
                id = pick_live(1'b0);
            end else if (pick < 65) begin
                op = OP_DROP;
                id = pick_live(1'b1);
            end else if (pick < 80) begin
                op = OP_SWEEP;
            end else if (pick < 90) begin
                op = OP_RESERVE;
                if ($urandom_range(0, 4) == 0) len = LEN_W'($urandom_range(0, 511));
            end else begin
                // noise: any opcode, any id, any length
                op = OPCODE_W'($urandom_range(0, 7));
                len = LEN_W'($urandom_range(0, 511));
            end
            send_request(op, id, len, 1'b0, '0);
        end

        req_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d replies: all opcodes, full table, lift burst",
                 requests_sent, replies_checked);
        $display("Replies by status: done %0d reduced %0d hanging %0d lost %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("  bad %0d full %0d empty %0d sat %0d",
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (errors == 0 && pending_replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rct_pkg.sv
rtl/rct_ctrl.sv
rtl/rct_datapath.sv
rtl/reference_count_table.sv
verif/reference_count_table_tb.sv
